// ===== design/microcoded_cpu_cycle_unit_assert.svh =====
// assertion macros shared by the cpu cycle unit modules
// no dependencies; included by files that carry concurrent checks
`ifndef MICROCODED_CPU_CYCLE_UNIT_ASSERT_SVH
`define MICROCODED_CPU_CYCLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define MCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mcc_pkg.sv =====
// shared types, constants and microword layout of the microcoded cpu cycle unit
// no dependencies; imported by every module of the block
package mcc_pkg;

    // main memory size, a power of two
    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam int CS_DEPTH  = 256;
    localparam int MAP_DEPTH = 256;
    localparam int REG_COUNT = 16;

    // register file slots used by the map decode
    localparam logic [3:0] IR_REG    = 4'd3;
    localparam logic [3:0] EXT12_REG = 4'd10;
    localparam logic [3:0] EXT11_REG = 4'd11;
    localparam logic [3:0] LOW8_REG  = 4'd12;

    localparam logic [15:0] LOW_BYTE_MASK = 16'h00FF;

    typedef logic [MEM_AW-1:0] t_maddr;
    typedef logic [15:0]       t_word;
    typedef logic [7:0]        t_upc;

    // memory-mapped character output word
    localparam t_maddr MEM_LAST = t_maddr'(MEM_WORDS - 1);

    typedef enum logic [2:0] {
        ACT_STEP       = 3'd0,
        ACT_LOAD_UWORD = 3'd1,
        ACT_LOAD_MAP   = 3'd2,
        ACT_WRITE_MEM  = 3'd3,
        ACT_WRITE_REG  = 3'd4,
        ACT_READ_REG   = 3'd5,
        ACT_READ_MEM   = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        COND_NEVER  = 2'd0,
        COND_NEG    = 2'd1,
        COND_ZERO   = 2'd2,
        COND_ALWAYS = 2'd3
    } t_cond;

    typedef enum logic [1:0] {
        ALU_PASS = 2'd0,
        ALU_ADD  = 2'd1,
        ALU_AND  = 2'd2,
        ALU_NOT  = 2'd3
    } t_alu_op;

    typedef enum logic [1:0] {
        SH_NONE  = 2'd0,
        SH_LEFT  = 2'd1,
        SH_LSR   = 2'd2,
        SH_ASR   = 2'd3
    } t_shift_op;

    // 33-bit microword, msb first
    typedef struct packed {
        logic      map;
        logic      amux;
        t_cond     cond;
        t_alu_op   alu;
        t_shift_op shift;
        logic      mbr;
        logic      mar;
        logic      rd;
        logic      wr;
        logic      no_store;
        logic [3:0] c;
        logic [3:0] b;
        logic [3:0] a;
        t_upc      addr;
    } t_mword;

    // port requests from the core to the stores
    typedef struct packed {
        logic   cs_we;
        t_upc   cs_waddr;
        t_mword cs_wdata;
        t_upc   cs_raddr;
        logic   map_we;
        t_upc   map_waddr;
        t_upc   map_wdata;
        t_upc   map_raddr;
        logic   mm_we;
        t_maddr mm_waddr;
        t_word  mm_wdata;
        logic   mm_re;
        t_maddr mm_raddr;
    } t_store_req;

    // work left for the finishing cycle of a transaction
    typedef struct packed {
        logic       host_rd;
        logic       mem_rd;
        logic       mem_wr;
        logic       map;
        logic       char_valid;
        logic [7:0] char_out;
    } t_fin;

    // one result transaction
    typedef struct packed {
        t_word      read_data;
        t_upc       micro_pc;
        logic       halted;
        logic       neg_flag;
        logic       zero_flag;
        logic       char_valid;
        logic [7:0] char_out;
    } t_result;

endpackage

// ===== design/mcc_stores.sv =====
// control store, opcode map and main memory with registered read ports
// depends on mcc_pkg
module mcc_stores import mcc_pkg::*; (
    input  logic       i_clk,
    input  t_store_req i_req,
    output t_mword     o_cs_q,
    output t_upc       o_map_q,
    output t_word      o_mm_q
);

    t_mword r_cs  [CS_DEPTH];
    t_upc   r_map [MAP_DEPTH];
    t_word  r_mm  [MEM_WORDS];

    t_mword r_cs_q;
    t_upc   r_map_q;
    t_word  r_mm_q;

    // control store: one write, one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.cs_we) begin
            r_cs[i_req.cs_waddr] <= i_req.cs_wdata;
        end
        r_cs_q <= r_cs[i_req.cs_raddr];
    end

    // opcode map
    always_ff @(posedge i_clk) begin
        if (i_req.map_we) begin
            r_map[i_req.map_waddr] <= i_req.map_wdata;
        end
        r_map_q <= r_map[i_req.map_raddr];
    end

    // main memory
    always_ff @(posedge i_clk) begin
        if (i_req.mm_we) begin
            r_mm[i_req.mm_waddr] <= i_req.mm_wdata;
        end
        if (i_req.mm_re) begin
            r_mm_q <= r_mm[i_req.mm_raddr];
        end
    end

    assign o_cs_q  = r_cs_q;
    assign o_map_q = r_map_q;
    assign o_mm_q  = r_mm_q;

endmodule

// ===== design/mcc_result_q.sv =====
// two-entry result queue between the core and the output channel
// depends on mcc_pkg and the assertion macro header
`include "microcoded_cpu_cycle_unit_assert.svh"

module mcc_result_q import mcc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [1:0] w_wpos;
    logic       w_pop;
    t_result    r_slot0;
    t_result    r_slot1;

    // occupancy
    assign w_pop  = (r_cnt != 2'd0) && !i_stall;
    assign w_wpos = r_cnt - {1'b0, w_pop};

    always_comb begin
        n_cnt = r_cnt;
        if (w_pop) begin
            n_cnt = n_cnt - 2'd1;
        end
        if (i_push) begin
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // slot shift on pop, or write at the first free slot
    always_ff @(posedge i_clk) begin
        if (i_push && (w_wpos == 2'd0)) begin
            r_slot0 <= i_result;
        end else if (w_pop) begin
            r_slot0 <= r_slot1;
        end
        if (i_push && (w_wpos == 2'd1)) begin
            r_slot1 <= i_result;
        end
    end

    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_result = r_slot0;

    `MCC_ASSERT_NOW(a_q_no_overflow, i_clk, i_rst_n, i_push, r_cnt != 2'd2, "result queue overflow")
    `MCC_ASSERT_NOW(a_q_count_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "result queue count out of range")

endmodule

// ===== design/mcc_core.sv =====
// datapath and control of one microcycle: register file, alu, shifter, mar, mbr,
// branch and map logic, host actions; depends on mcc_pkg and the assertion header
`include "microcoded_cpu_cycle_unit_assert.svh"

module mcc_core import mcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [11:0] i_index,
    input  logic [32:0] i_data,
    input  logic        i_q_full,
    output logic        o_push,
    output t_result     o_result,
    output t_store_req  o_req,
    input  t_mword      i_cs_q,
    input  t_upc        i_map_q,
    input  t_word       i_mm_q
);

    t_word  r_rf [REG_COUNT];
    t_word  n_rf [REG_COUNT];
    t_upc   r_upc, n_upc;
    t_word  r_mar, n_mar;
    t_word  r_mbr, n_mbr;
    t_word  r_alu, n_alu;
    logic   r_rpend, n_rpend;
    logic   r_wpend, n_wpend;
    logic   r_fin, n_fin;
    t_fin   r_fin_kind, n_fin_kind;
    t_upc   r_mw_tag;
    logic   r_mw_fresh;

    t_mword mw;
    logic   w_accept;
    logic   w_mw_ok;
    logic   w_step;
    t_word  w_a, w_b, w_amux, w_alu, w_sh;
    t_word  w_mar_n, w_mbr_n, w_ir_n;
    logic   w_take;
    logic   w_rd_done, w_wr_done, w_last;

    // handshake: hold off while finishing, while the microword is stale, or when full
    assign w_mw_ok  = r_mw_fresh && (r_mw_tag == r_upc);
    assign o_stall  = r_fin || !w_mw_ok || i_q_full;
    assign w_accept = i_valid && !o_stall;
    assign w_step   = w_accept && (i_action == ACT_STEP);
    assign mw       = i_cs_q;

    // operand read and amux
    assign w_a    = r_rf[mw.a];
    assign w_b    = r_rf[mw.b];
    assign w_amux = mw.amux ? r_mbr : w_a;

    // alu
    always_comb begin
        case (mw.alu)
            ALU_PASS: w_alu = w_amux;
            ALU_ADD:  w_alu = w_amux + w_b;
            ALU_AND:  w_alu = w_amux & w_b;
            ALU_NOT:  w_alu = ~w_amux;
            default:  w_alu = w_amux;
        endcase
    end

    // shifter
    always_comb begin
        case (mw.shift)
            SH_NONE: w_sh = w_alu;
            SH_LEFT: w_sh = {w_alu[14:0], 1'b0};
            SH_LSR:  w_sh = {1'b0, w_alu[15:1]};
            SH_ASR:  w_sh = {w_alu[15], w_alu[15:1]};
            default: w_sh = w_alu;
        endcase
    end

    // branch condition on the fresh alu result
    always_comb begin
        case (mw.cond)
            COND_NEVER:  w_take = 1'b0;
            COND_NEG:    w_take = w_alu[15];
            COND_ZERO:   w_take = (w_alu == 16'd0);
            COND_ALWAYS: w_take = 1'b1;
            default:     w_take = 1'b0;
        endcase
    end

    // values after this microword's loads
    assign w_mar_n   = mw.mar ? w_b : r_mar;
    assign w_mbr_n   = mw.mbr ? w_sh : r_mbr;
    assign w_ir_n    = (!mw.no_store && (mw.c == IR_REG)) ? w_sh : r_rf[IR_REG];
    assign w_rd_done = mw.rd && r_rpend;
    assign w_wr_done = mw.wr && r_wpend;
    assign w_last    = (t_maddr'(w_mar_n) == MEM_LAST);

    // next state, store requests and result
    always_comb begin
        n_rf       = r_rf;
        n_upc      = r_upc;
        n_mar      = r_mar;
        n_mbr      = r_mbr;
        n_alu      = r_alu;
        n_rpend    = r_rpend;
        n_wpend    = r_wpend;
        n_fin      = 1'b0;
        n_fin_kind = r_fin_kind;

        o_req           = '0;
        o_req.cs_raddr  = r_upc;
        o_req.map_raddr = w_ir_n[15:8];
        o_req.mm_raddr  = t_maddr'(w_mar_n);

        o_push   = 1'b0;
        o_result = '0;

        if (r_fin) begin
            // finishing cycle: memory data and map entry are in
            o_push              = 1'b1;
            o_result.char_valid = r_fin_kind.char_valid;
            o_result.char_out   = r_fin_kind.char_out;
            if (r_fin_kind.host_rd) begin
                o_result.read_data = i_mm_q;
            end
            if (r_fin_kind.mem_rd) begin
                n_mbr = i_mm_q;
                if (r_fin_kind.mem_wr) begin
                    o_req.mm_we    = 1'b1;
                    o_req.mm_waddr = t_maddr'(r_mar);
                    o_req.mm_wdata = i_mm_q;
                    if (t_maddr'(r_mar) == MEM_LAST) begin
                        o_req.mm_wdata      = 16'd0;
                        o_result.char_valid = 1'b1;
                        o_result.char_out   = i_mm_q[7:0];
                    end
                end
            end
            if (r_fin_kind.map) begin
                n_upc = i_map_q;
            end
        end else if (w_accept) begin
            case (t_action'(i_action))
                ACT_STEP: begin
                    n_alu = w_alu;
                    n_mar = w_mar_n;
                    n_mbr = w_mbr_n;
                    if (!mw.no_store) begin
                        n_rf[mw.c] = w_sh;
                    end
                    n_upc = w_take ? mw.addr : (r_upc + 8'd1);
                    if (mw.rd) begin
                        n_rpend = !r_rpend;
                    end
                    if (mw.wr) begin
                        n_wpend = !r_wpend;
                    end
                    n_fin_kind = '0;
                    // write completes now unless it waits on a completing read
                    if (w_wr_done && !w_rd_done) begin
                        o_req.mm_we    = 1'b1;
                        o_req.mm_waddr = t_maddr'(w_mar_n);
                        o_req.mm_wdata = w_mbr_n;
                        if (w_last) begin
                            o_req.mm_wdata        = 16'd0;
                            o_result.char_valid   = 1'b1;
                            o_result.char_out     = w_mbr_n[7:0];
                            n_fin_kind.char_valid = 1'b1;
                            n_fin_kind.char_out   = w_mbr_n[7:0];
                        end
                    end
                    if (w_rd_done) begin
                        o_req.mm_re = 1'b1;
                    end
                    // map decode of the ir as left by the c write
                    if (mw.map) begin
                        n_rf[EXT12_REG] = {{4{w_ir_n[11]}}, w_ir_n[11:0]};
                        n_rf[EXT11_REG] = {{5{w_ir_n[10]}}, w_ir_n[10:0]};
                        n_rf[LOW8_REG]  = w_ir_n & LOW_BYTE_MASK;
                    end
                    if (w_rd_done || mw.map) begin
                        n_fin             = 1'b1;
                        n_fin_kind.mem_rd = w_rd_done;
                        n_fin_kind.mem_wr = w_rd_done && w_wr_done;
                        n_fin_kind.map    = mw.map;
                    end else begin
                        o_push = 1'b1;
                    end
                end
                ACT_LOAD_UWORD: begin
                    o_req.cs_we    = (i_index[11:8] == 4'd0);
                    o_req.cs_waddr = i_index[7:0];
                    o_req.cs_wdata = t_mword'(i_data);
                    o_push         = 1'b1;
                end
                ACT_LOAD_MAP: begin
                    o_req.map_we    = (i_index[11:8] == 4'd0);
                    o_req.map_waddr = i_index[7:0];
                    o_req.map_wdata = i_data[7:0];
                    o_push          = 1'b1;
                end
                ACT_WRITE_MEM: begin
                    o_req.mm_we    = 1'b1;
                    o_req.mm_waddr = t_maddr'(i_index);
                    o_req.mm_wdata = i_data[15:0];
                    o_push         = 1'b1;
                end
                ACT_WRITE_REG: begin
                    if (i_index[11:4] == 8'd0) begin
                        n_rf[i_index[3:0]] = i_data[15:0];
                    end
                    o_push = 1'b1;
                end
                ACT_READ_REG: begin
                    if (i_index[11:4] == 8'd0) begin
                        o_result.read_data = r_rf[i_index[3:0]];
                    end
                    o_push = 1'b1;
                end
                ACT_READ_MEM: begin
                    o_req.mm_re    = 1'b1;
                    o_req.mm_raddr = t_maddr'(i_index);
                    n_fin          = 1'b1;
                    n_fin_kind     = '0;
                    n_fin_kind.host_rd = 1'b1;
                end
                default: begin
                    o_push = 1'b1;
                end
            endcase
        end

        o_result.micro_pc  = n_upc;
        o_result.halted    = (n_upc == 8'd0);
        o_result.neg_flag  = n_alu[15];
        o_result.zero_flag = (n_alu == 16'd0);
    end

    // control and architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf       <= '{default: '0};
            r_upc      <= '0;
            r_mar      <= '0;
            r_mbr      <= '0;
            r_alu      <= '0;
            r_rpend    <= 1'b0;
            r_wpend    <= 1'b0;
            r_fin      <= 1'b0;
            r_mw_tag   <= '0;
            r_mw_fresh <= 1'b0;
        end else begin
            r_rf       <= n_rf;
            r_upc      <= n_upc;
            r_mar      <= n_mar;
            r_mbr      <= n_mbr;
            r_alu      <= n_alu;
            r_rpend    <= n_rpend;
            r_wpend    <= n_wpend;
            r_fin      <= n_fin;
            r_mw_tag   <= r_upc;
            r_mw_fresh <= !(o_req.cs_we && (o_req.cs_waddr == r_upc));
        end
    end

    // finishing work carried to the finishing cycle
    always_ff @(posedge i_clk) begin
        r_fin_kind <= n_fin_kind;
    end

    `MCC_ASSERT_NEXT(a_fin_single, i_clk, i_rst_n, r_fin, !r_fin, "finish phase longer than one cycle")
    `MCC_ASSERT_NEXT(a_fin_follows, i_clk, i_rst_n, w_step && (w_rd_done || mw.map), r_fin, "read or map step did not enter finish phase")
    `MCC_ASSERT_NOW(a_mem_port, i_clk, i_rst_n, o_req.mm_we, !o_req.mm_re, "main memory read and write in one cycle")

endmodule

// ===== design/microcoded_cpu_cycle_unit.sv =====
// Microprogrammed 16-bit cpu, one microcycle per step transaction.
// Input channel: i_valid / o_stall with i_action, i_index, i_data. Host actions
// load the control store, opcode map, memory and registers, or read them back;
// the step action runs one microcycle from the microword at the micro pc.
// Output channel: o_valid / i_stall, one result transaction per input transaction.
// A memory read, a step that completes a memory read and a step with the map bit
// go through a finishing cycle before their result is queued.
// Throughput: host actions other than memory reads one per cycle while the result
// queue has room. A step that moves the micro pc makes the control store read port
// fetch the new microword, and the input stalls until it is in; a step with the map
// bit moves the micro pc twice. A step that completes a read finishes while the new
// microword is fetched. Loading the microword at the current micro pc stalls too.
// Reset (synchronous, active low) clears registers, micro pc, mar, mbr, flags
// and pending accesses; the stores keep their contents and are undefined until
// written. The first cycle after reset fetches the microword, with o_stall high.
// A two-entry result queue lets the receiver stall without blocking the input
// for one more transaction; o_stall rises when the queue is full.
// Depends on mcc_pkg, mcc_core, mcc_stores and mcc_result_q.
module microcoded_cpu_cycle_unit import mcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [11:0] i_index,
    input  logic [32:0] i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_read_data,
    output logic [7:0]  o_micro_pc,
    output logic        o_halted,
    output logic        o_neg_flag,
    output logic        o_zero_flag,
    output logic        o_char_valid,
    output logic [7:0]  o_char_out
);

    t_store_req w_req;
    t_mword     w_cs_q;
    t_upc       w_map_q;
    t_word      w_mm_q;
    logic       w_push;
    logic       w_q_full;
    t_result    w_core_result;
    t_result    w_out_result;

    // execution core
    mcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .i_index  (i_index),
        .i_data   (i_data),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_result (w_core_result),
        .o_req    (w_req),
        .i_cs_q   (w_cs_q),
        .i_map_q  (w_map_q),
        .i_mm_q   (w_mm_q)
    );

    // control store, opcode map, main memory
    mcc_stores u_stores (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_cs_q  (w_cs_q),
        .o_map_q (w_map_q),
        .o_mm_q  (w_mm_q)
    );

    // result queue
    mcc_result_q u_result_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_core_result),
        .o_full   (w_q_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (w_out_result)
    );

    // result fields to ports
    assign o_read_data  = w_out_result.read_data;
    assign o_micro_pc   = w_out_result.micro_pc;
    assign o_halted     = w_out_result.halted;
    assign o_neg_flag   = w_out_result.neg_flag;
    assign o_zero_flag  = w_out_result.zero_flag;
    assign o_char_valid = w_out_result.char_valid;
    assign o_char_out   = w_out_result.char_out;

endmodule

// ===== test/microcoded_cpu_cycle_unit_tb.sv =====
// self-checking testbench for the microcoded cpu cycle unit
// depends on mcc_pkg and microcoded_cpu_cycle_unit; drives host actions and
// microcycle steps, predicts every result transaction and compares field by field
module microcoded_cpu_cycle_unit_tb import mcc_pkg::*; ();

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 440;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD = 400;

    // two copies of the cpu state: one runs ahead while stimulus is built,
    // one follows the transactions the block actually accepts
    localparam int GEN_VIEW = 0;
    localparam int DUT_VIEW = 1;

    // action code the block does not define
    localparam logic [2:0] ACT_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [2:0]  act;
        logic [11:0] idx;
        logic [32:0] data;
    } t_cmd;

    // store entry a step would read before anything was written there
    typedef enum int {
        HOLE_NONE,
        HOLE_UWORD,
        HOLE_MAP,
        HOLE_MEM
    } t_hole;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_action = '0;
    logic [11:0] i_index = '0;
    logic [32:0] i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_read_data;
    logic [7:0]  o_micro_pc;
    logic        o_halted;
    logic        o_neg_flag;
    logic        o_zero_flag;
    logic        o_char_valid;
    logic [7:0]  o_char_out;

    microcoded_cpu_cycle_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_index      (i_index),
        .i_data       (i_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_micro_pc   (o_micro_pc),
        .o_halted     (o_halted),
        .o_neg_flag   (o_neg_flag),
        .o_zero_flag  (o_zero_flag),
        .o_char_valid (o_char_valid),
        .o_char_out   (o_char_out)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // cpu state, one copy per view
    bit [32:0] cs_img  [2][CS_DEPTH];
    bit [7:0]  map_img [2][MAP_DEPTH];
    bit [15:0] mem_img [2][MEM_WORDS];
    bit [15:0] rf_img  [2][REG_COUNT];
    bit [7:0]  upc_img [2];
    bit [15:0] mar_img [2];
    bit [15:0] mbr_img [2];
    bit [15:0] alu_img [2];
    bit        rdp_img [2];
    bit        wrp_img [2];

    // entries written so far, tracked on the generation view only
    bit cs_set  [CS_DEPTH];
    bit map_set [MAP_DEPTH];
    bit mem_set [MEM_WORDS];

    t_cmd    cmd_queue[$];
    t_result due_results[$];

    int send_idle_pct = 8;
    int recv_idle_pct = 77;
    int hold_req = 0;
    int errors = 0;
    int cycles = 0;
    int steps_sent = 0;
    int chars_seen = 0;
    int results_seen = 0;

    // one host action or microcycle on view s; a hole leaves the state untouched
    function automatic void cpu_apply(input int s, input t_cmd c, output t_result r,
                                      output t_hole hole, output int unsigned hole_at);
        t_mword mw;
        t_word  abus, bbus, v, sh, mar_n, mbr_n, ir_n;
        t_maddr ma;
        t_upc   upc_n;
        logic   take;
        bit     ahead;
        ahead = (s == GEN_VIEW);
        hole = HOLE_NONE;
        hole_at = 0;
        r = '0;
        case (c.act)
            ACT_STEP: begin
                if (ahead && !cs_set[upc_img[s]]) begin
                    hole = HOLE_UWORD;
                    hole_at = upc_img[s];
                    return;
                end
                mw = t_mword'(cs_img[s][upc_img[s]]);
                abus = rf_img[s][mw.a];
                bbus = rf_img[s][mw.b];
                v = mw.amux ? t_word'(mbr_img[s]) : abus;
                case (mw.alu)
                    ALU_ADD: v = v + bbus;
                    ALU_AND: v = v & bbus;
                    ALU_NOT: v = ~v;
                    default: ;
                endcase
                case (mw.shift)
                    SH_LEFT: sh = {v[14:0], 1'b0};
                    SH_LSR:  sh = {1'b0, v[15:1]};
                    SH_ASR:  sh = {v[15], v[15:1]};
                    default: sh = v;
                endcase
                mar_n = mw.mar ? bbus : t_word'(mar_img[s]);
                ir_n = (!mw.no_store && mw.c == IR_REG) ? sh : t_word'(rf_img[s][IR_REG]);
                ma = t_maddr'(mar_n);
                if (ahead && mw.rd && rdp_img[s] && !mem_set[ma]) begin
                    hole = HOLE_MEM;
                    hole_at = ma;
                    return;
                end
                if (ahead && mw.map && !map_set[ir_n[15:8]]) begin
                    hole = HOLE_MAP;
                    hole_at = ir_n[15:8];
                    return;
                end
                // datapath writeback
                alu_img[s] = v;
                mar_img[s] = mar_n;
                if (!mw.no_store) rf_img[s][mw.c] = sh;
                mbr_n = mw.mbr ? sh : t_word'(mbr_img[s]);
                // next micro pc
                take = (mw.cond == COND_ALWAYS) || (mw.cond == COND_ZERO && v == 16'h0000) ||
                       (mw.cond == COND_NEG && v[15]);
                upc_n = take ? mw.addr : t_upc'(upc_img[s] + 8'd1);
                // memory access over a starting and a completing step, read handled first
                if (mw.rd) begin
                    if (rdp_img[s]) begin
                        mbr_n = mem_img[s][ma];
                        rdp_img[s] = 1'b0;
                    end else begin
                        rdp_img[s] = 1'b1;
                    end
                end
                if (mw.wr) begin
                    if (wrp_img[s]) begin
                        mem_img[s][ma] = mbr_n;
                        wrp_img[s] = 1'b0;
                        if (ahead) mem_set[ma] = 1'b1;
                        if (ma == MEM_LAST) begin
                            r.char_valid = 1'b1;
                            r.char_out = mbr_n[7:0];
                            mem_img[s][ma] = '0;
                        end
                    end else begin
                        wrp_img[s] = 1'b1;
                    end
                end
                mbr_img[s] = mbr_n;
                // ir decode through the opcode map
                if (mw.map) begin
                    rf_img[s][EXT12_REG] = {{4{ir_n[11]}}, ir_n[11:0]};
                    rf_img[s][EXT11_REG] = {{5{ir_n[10]}}, ir_n[10:0]};
                    rf_img[s][LOW8_REG] = ir_n & LOW_BYTE_MASK;
                    upc_n = map_img[s][ir_n[15:8]];
                end
                upc_img[s] = upc_n;
            end
            ACT_LOAD_UWORD: begin
                if (c.idx < CS_DEPTH) begin
                    cs_img[s][c.idx[7:0]] = c.data;
                    if (ahead) cs_set[c.idx[7:0]] = 1'b1;
                end
            end
            ACT_LOAD_MAP: begin
                if (c.idx < MAP_DEPTH) begin
                    map_img[s][c.idx[7:0]] = c.data[7:0];
                    if (ahead) map_set[c.idx[7:0]] = 1'b1;
                end
            end
            ACT_WRITE_MEM: begin
                mem_img[s][t_maddr'(c.idx)] = c.data[15:0];
                if (ahead) mem_set[t_maddr'(c.idx)] = 1'b1;
            end
            ACT_WRITE_REG: begin
                if (c.idx < REG_COUNT) rf_img[s][c.idx[3:0]] = c.data[15:0];
            end
            ACT_READ_REG: begin
                if (c.idx < REG_COUNT) r.read_data = rf_img[s][c.idx[3:0]];
            end
            ACT_READ_MEM: begin
                if (ahead && !mem_set[t_maddr'(c.idx)]) begin
                    hole = HOLE_MEM;
                    hole_at = t_maddr'(c.idx);
                    return;
                end
                r.read_data = mem_img[s][t_maddr'(c.idx)];
            end
            default: ;
        endcase
        r.micro_pc = upc_img[s];
        r.halted = (upc_img[s] == 8'd0);
        r.neg_flag = alu_img[s][15];
        r.zero_flag = (alu_img[s] == 16'h0000);
    endfunction

    function automatic logic [32:0] rand_data33();
        logic [32:0] d;
        d[31:0] = $urandom();
        d[32] = 1'($urandom_range(0, 1));
        return d;
    endfunction

    // words biased toward the output word address and the sign boundary
    function automatic t_word rand_word();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return {4'($urandom_range(0, 15)), 12'hFFF};
            2: return 16'h0000;
            3: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    // micro pc targets mostly in a small window so programs loop back
    function automatic t_upc rand_target();
        if ($urandom_range(0, 99) < 80) return t_upc'($urandom_range(0, 15));
        return t_upc'($urandom_range(0, 255));
    endfunction

    function automatic logic [32:0] rand_uword();
        t_mword w;
        w = t_mword'(rand_data33());
        w.map = ($urandom_range(0, 99) < 12);
        w.rd = ($urandom_range(0, 99) < 35);
        w.wr = ($urandom_range(0, 99) < 35);
        w.addr = rand_target();
        return w;
    endfunction

    // queue a transaction, first filling any store entry it would read unwritten
    function automatic void queue_cmd(logic [2:0] act, logic [11:0] idx, logic [32:0] data);
        t_cmd        c, fix;
        t_result     r;
        t_hole       hole;
        int unsigned at;
        c.act = act;
        c.idx = idx;
        c.data = data;
        cpu_apply(GEN_VIEW, c, r, hole, at);
        while (hole != HOLE_NONE) begin
            fix.idx = 12'(at);
            case (hole)
                HOLE_UWORD: begin
                    fix.act = ACT_LOAD_UWORD;
                    fix.data = rand_uword();
                end
                HOLE_MAP: begin
                    fix.act = ACT_LOAD_MAP;
                    fix.data = rand_data33();
                    fix.data[7:0] = rand_target();
                end
                default: begin
                    fix.act = ACT_WRITE_MEM;
                    fix.data = rand_data33();
                    fix.data[15:0] = rand_word();
                end
            endcase
            cpu_apply(GEN_VIEW, fix, r, hole, at);
            cmd_queue.push_back(fix);
            cpu_apply(GEN_VIEW, c, r, hole, at);
        end
        cmd_queue.push_back(c);
    endfunction

    // mostly microcycles, with host loads and reads mixed in and some noise
    function automatic void queue_random_cmd();
        int unsigned pick;
        logic [11:0] idx;
        logic [32:0] data;
        pick = $urandom_range(0, 99);
        data = rand_data33();
        idx = ($urandom_range(0, 9) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 15));
        if (pick < 8) begin
            queue_cmd(3'($urandom_range(0, 7)), 12'($urandom()), data);
        end else if (pick < 20) begin
            data[15:0] = rand_word();
            queue_cmd(ACT_WRITE_REG, idx, data);
        end else if (pick < 27) begin
            queue_cmd(ACT_LOAD_UWORD, idx, rand_uword());
        end else if (pick < 31) begin
            data[7:0] = rand_target();
            queue_cmd(ACT_LOAD_MAP, 12'($urandom_range(0, 255)), data);
        end else if (pick < 35) begin
            data[15:0] = rand_word();
            queue_cmd(ACT_WRITE_MEM, 12'($urandom()), data);
        end else if (pick < 40) begin
            queue_cmd(ACT_READ_REG, idx, data);
        end else if (pick < 44) begin
            queue_cmd(ACT_READ_MEM, 12'($urandom()), data);
        end else begin
            queue_cmd(ACT_STEP, 12'($urandom()), data);
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    // driver: present queued transactions, predict each one as it is accepted
    always @(posedge i_clk) begin
        t_result     want;
        t_hole       hole;
        int unsigned at;
        logic        taken;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            taken = i_valid && !o_stall;
            if (taken) begin
                cpu_apply(DUT_VIEW, cmd_queue[0], want, hole, at);
                due_results.push_back(want);
                if (cmd_queue[0].act == ACT_STEP) steps_sent++;
                void'(cmd_queue.pop_front());
            end
            if (i_valid && !taken) begin
                // stalled, payload held
            end else if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_action <= cmd_queue[0].act;
                i_index <= cmd_queue[0].idx;
                i_data <= cmd_queue[0].data;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall: random, or a long hold counted here when requested
    always @(posedge i_clk) begin
        int hold_left;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_req > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_req - 1;
            hold_req = 0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (o_char_valid === 1'b1) chars_seen++;
            if (due_results.size() == 0) begin
                $error("result transaction with no prediction pending");
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("read_data", want.read_data, o_read_data);
                check_field("micro_pc", 16'(want.micro_pc), 16'(o_micro_pc));
                check_field("halted", 16'(want.halted), 16'(o_halted));
                check_field("neg_flag", 16'(want.neg_flag), 16'(o_neg_flag));
                check_field("zero_flag", 16'(want.zero_flag), 16'(o_zero_flag));
                check_field("char_valid", 16'(want.char_valid), 16'(o_char_valid));
                check_field("char_out", 16'(want.char_out), 16'(o_char_out));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_mword w;
        int     ph;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty state, out of range indices, unknown action, extremes
        queue_cmd(ACT_READ_REG, 12'd0, 33'd0);
        queue_cmd(ACT_WRITE_REG, 12'hFFF, 33'h1_FFFF_FFFF);
        queue_cmd(ACT_READ_REG, 12'hFFF, 33'h1_FFFF_FFFF);
        queue_cmd(ACT_UNKNOWN, 12'hFFF, 33'h1_FFFF_FFFF);
        queue_cmd(ACT_LOAD_UWORD, 12'h100, 33'h1_FFFF_FFFF);
        queue_cmd(ACT_LOAD_MAP, 12'hFFF, 33'h1_FFFF_FFFF);
        queue_cmd(ACT_WRITE_REG, 12'd1, 33'h1_FFFF_8041);
        queue_cmd(ACT_WRITE_REG, 12'd15, 33'h0_0000_FFFF);
        queue_cmd(ACT_WRITE_REG, 12'(IR_REG), 33'h0_0000_87FF);
        queue_cmd(ACT_WRITE_MEM, 12'd0, 33'd0);
        queue_cmd(ACT_WRITE_MEM, 12'hFFF, 33'h1_FFFF_FFFF);
        queue_cmd(ACT_READ_MEM, 12'hFFF, 33'd0);
        // pass with mbr and mar loads, first half of a write to the output word
        w = '0;
        w.alu = ALU_PASS; w.shift = SH_NONE; w.cond = COND_ALWAYS; w.addr = 8'd1;
        w.a = 4'd1; w.b = 4'd15; w.mbr = 1'b1; w.mar = 1'b1; w.wr = 1'b1; w.no_store = 1'b1;
        queue_cmd(ACT_LOAD_UWORD, 12'd0, w);
        // add with left shift, finishes the write and emits a character
        w = '0;
        w.alu = ALU_ADD; w.shift = SH_LEFT; w.cond = COND_NEG; w.addr = 8'd9;
        w.a = 4'd1; w.b = 4'd1; w.c = 4'd2; w.wr = 1'b1;
        queue_cmd(ACT_LOAD_UWORD, 12'd1, w);
        // and with logical right shift, starts a read, decodes ir
        w = '0;
        w.alu = ALU_AND; w.shift = SH_LSR; w.a = 4'd15; w.b = 4'd1; w.c = 4'd4;
        w.rd = 1'b1; w.map = 1'b1;
        queue_cmd(ACT_LOAD_UWORD, 12'd2, w);
        queue_cmd(ACT_LOAD_MAP, 12'h087, 33'd3);
        // invert of mbr with arithmetic shift, completes the read, back to zero
        w = '0;
        w.amux = 1'b1; w.alu = ALU_NOT; w.shift = SH_ASR; w.c = 4'd5; w.rd = 1'b1;
        w.cond = COND_ALWAYS; w.addr = 8'd0;
        queue_cmd(ACT_LOAD_UWORD, 12'd3, w);
        repeat (4) queue_cmd(ACT_STEP, 12'd0, 33'd0);
        queue_cmd(ACT_READ_MEM, 12'hFFF, 33'd0);
        queue_cmd(ACT_READ_REG, 12'(EXT12_REG), 33'd0);
        queue_cmd(ACT_READ_REG, 12'(EXT11_REG), 33'd0);

        // random phases: sender idles lightly, then the receiver, then neither but for one long receiver hold
        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 77 : 0;
            recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 8 : 0;
            if (ph == 2) hold_req = LONG_HOLD;
            repeat (PHASE_ITEMS) queue_random_cmd();
            // sender waits here until every predicted result has come back
            while (cmd_queue.size() != 0 || due_results.size() != 0) @(negedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d result transactions, %0d of them microcycles", results_seen,
                 steps_sent);
        $display("%0d characters emitted, %0d mismatches", chars_seen, errors);
        if (errors == 0 && due_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
